[hw/rtl/hpp_pkg.sv]
// Package for the holiday period partition block.
// Holds the word types, status codes, cell operations and controller states.
// No dependencies; every other file imports it.
`timescale 1ns / 1ps

package hpp_pkg;

  // Day numbers are fixed at the width of the word fields.
  localparam int DAY_BITS = 20;
  localparam int CFG_IDX_BITS = 2;

  typedef logic [DAY_BITS-1:0] hpp_day_t;

  // Input action codes.
  typedef enum logic {
    ACT_ADD  = 1'b0,
    ACT_READ = 1'b1
  } hpp_action_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_APPLIED = 3'd0,
    ST_NOT_YET = 3'd1,
    ST_OUTSIDE = 3'd2,
    ST_FULL    = 3'd3,
    ST_READ    = 3'd4
  } hpp_status_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_EPOCH_START = 2'd0,
    CFG_EPOCH_END   = 2'd1,
    CFG_AS_OF_DAY   = 2'd2,
    CFG_UNUSED      = 2'd3
  } hpp_cfg_idx_t;

  // Input word.
  typedef struct packed {
    hpp_action_t action;
    hpp_day_t    announced_day;
    hpp_day_t    holiday_start;
    hpp_day_t    holiday_end;
  } hpp_in_t;

  // Result word.
  typedef struct packed {
    hpp_status_t status;
    hpp_day_t    period_start;
    hpp_day_t    period_end;
    logic        last;
  } hpp_out_t;

  // Operation applied to every cell of the chain together.
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_ROTATE = 2'd2,
    OP_CLEAR  = 2'd3
  } hpp_cell_op_t;

  // Control bundle broadcast from the controller to every cell.
  typedef struct packed {
    hpp_cell_op_t op;
    hpp_day_t     ins_day;   // day to insert, or new head day on clear
    hpp_day_t     head_day;  // head cell's day, wraps round on rotate
    hpp_day_t     key_s;     // first boundary to look up
    hpp_day_t     key_e;     // second boundary to look up
  } hpp_cell_ctl_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DECIDE,
    S_INS_S,
    S_INS_E,
    S_REPORT,
    S_READ
  } hpp_state_t;

endpackage

[hw/rtl/hpp_cell.sv]
// One cell of the boundary chain: holds one sub-period start day and its valid bit.
// Depends on hpp_pkg for the day type and the control bundle.
`timescale 1ns / 1ps

module hpp_cell
  import hpp_pkg::*;
#(
  parameter bit IS_HEAD = 1'b0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  hpp_cell_ctl_t ctl,
  input  hpp_day_t      left_day,
  input  logic          left_valid,
  input  hpp_day_t      right_day,
  input  logic          right_valid,
  output hpp_day_t      day_o,
  output logic          valid_o,
  output logic          match_s_o,
  output logic          match_e_o
);

  hpp_day_t day_r, day_nxt;
  logic     valid_r, valid_nxt;
  logic     lt_self, lt_left;

  // Ordering against the day being inserted.
  assign lt_self = valid_r && (day_r < ctl.ins_day);
  assign lt_left = left_valid && (left_day < ctl.ins_day);

  // Next contents for each chain operation.
  always_comb begin
    day_nxt   = day_r;
    valid_nxt = valid_r;
    case (ctl.op)
      OP_INSERT: begin
        if (lt_self) begin
          day_nxt = day_r;
        end else if (IS_HEAD || lt_left) begin
          day_nxt   = ctl.ins_day;
          valid_nxt = 1'b1;
        end else begin
          day_nxt   = left_day;
          valid_nxt = valid_r || left_valid;
        end
      end
      OP_ROTATE: begin
        if (valid_r) begin
          day_nxt = right_valid ? right_day : ctl.head_day;
        end
      end
      OP_CLEAR: begin
        day_nxt   = IS_HEAD ? ctl.ins_day : day_r;
        valid_nxt = IS_HEAD;
      end
      default: begin
        day_nxt   = day_r;
        valid_nxt = valid_r;
      end
    endcase
  end

  // State registers; the head cell comes out of reset holding day zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      day_r   <= '0;
      valid_r <= IS_HEAD;
    end else begin
      day_r   <= day_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign day_o     = day_r;
  assign valid_o   = valid_r;
  assign match_s_o = valid_r && (day_r == ctl.key_s);
  assign match_e_o = valid_r && (day_r == ctl.key_e);

endmodule

[hw/rtl/holiday_period_partition.sv]
// Channel   Direction  Handshake          Word
// in_       input      in_valid/in_stall  hpp_in_t: action, announced day, holiday span
// out_      output     out_valid/out_stall hpp_out_t: status, sub-period, last flag
// cfg_      input      cfg_valid/cfg_ready index and data of one register
//
// An add word is compared against every cell, decided, then applied as up to two sorted
// inserts along the cell chain: in_stall stays high through the check, decide, insert and
// report states, and a rejected add goes from decide straight to report.
// A read word rotates the chain once per result, one sub-period a cycle while out_stall
// is low; out_stall holds the rotation and the add result.
// A synchronous reset leaves the table holding only day zero; no clearing pass.
// Depends on hpp_pkg and hpp_cell.
`timescale 1ns / 1ps

module holiday_period_partition
  import hpp_pkg::*;
#(
  parameter int MAX_PERIODS = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  hpp_in_t                 in_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output hpp_out_t                out_data,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  hpp_day_t                cfg_data
);

  localparam int CNT_W = $clog2(MAX_PERIODS + 1);

  // Configuration registers.
  hpp_day_t epoch_start_r, epoch_end_r, as_of_r;

  // Controller registers.
  hpp_state_t       state_r, state_nxt;
  hpp_in_t          item_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  hpp_status_t      stat_r, stat_nxt;
  logic             add_s_r, add_s_nxt;
  logic             add_e_r, add_e_nxt;
  logic [MAX_PERIODS-1:0] ms_r, me_r;

  // Output register.
  logic     out_valid_r, out_valid_nxt;
  hpp_out_t out_r, out_nxt;

  // Chain wiring.
  hpp_cell_ctl_t          ctl;
  hpp_day_t               cell_day [MAX_PERIODS];
  logic [MAX_PERIODS-1:0] cell_valid;
  logic [MAX_PERIODS-1:0] match_s, match_e;

  logic             in_acc, cfg_acc, slot_free, last_read;
  logic             cfg_clear;
  hpp_cell_op_t     fsm_op;
  hpp_day_t         key_e;
  logic [CNT_W:0]   need_sum;
  logic             outside;
  hpp_day_t         read_end;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign slot_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign cfg_clear = cfg_acc && ((cfg_index == CFG_EPOCH_START) ||
                                 (cfg_index == CFG_EPOCH_END));

  // Second boundary is the day after the holiday ends.
  assign key_e = item_r.holiday_end + hpp_day_t'(1);

  // Range check of the holiday against the epoch.
  assign outside = (item_r.holiday_start < epoch_start_r) ||
                   (item_r.holiday_end > epoch_end_r) ||
                   (item_r.holiday_start > item_r.holiday_end);

  // Entries needed after the boundaries still missing are added.
  assign need_sum = {1'b0, count_r} + (CNT_W + 1)'(add_s_nxt) + (CNT_W + 1)'(add_e_nxt);

  assign last_read = ((k_r + CNT_W'(1)) == count_r);

  // End of the sub-period at the head of the chain during readout.
  assign read_end = last_read ? epoch_end_r : (cell_day[1] - hpp_day_t'(1));

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epoch_start_r <= '0;
      epoch_end_r   <= '1;
      as_of_r       <= '1;
    end else if (cfg_acc) begin
      unique case (cfg_index)
        CFG_EPOCH_START: epoch_start_r <= cfg_data;
        CFG_EPOCH_END:   epoch_end_r   <= cfg_data;
        CFG_AS_OF_DAY:   as_of_r       <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_data.action == ACT_READ) ? S_READ : S_CHECK;
        end
      end
      S_CHECK:  state_nxt = S_DECIDE;
      S_DECIDE: state_nxt = (stat_nxt == ST_APPLIED) ? S_INS_S : S_REPORT;
      S_INS_S:  state_nxt = S_INS_E;
      S_INS_E:  state_nxt = S_REPORT;
      S_REPORT: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_READ: begin
        if (slot_free && last_read) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Controller outputs: chain operation, decision, counters and result word.
  always_comb begin
    fsm_op        = OP_HOLD;
    stat_nxt      = stat_r;
    add_s_nxt     = add_s_r;
    add_e_nxt     = add_e_r;
    count_nxt     = count_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    unique case (state_r)
      S_IDLE: begin
        k_nxt = '0;
      end
      S_CHECK: ;
      S_DECIDE: begin
        add_s_nxt = (item_r.holiday_start != epoch_start_r) && !(|ms_r);
        add_e_nxt = (item_r.holiday_end < epoch_end_r) && !(|me_r);
        if (item_r.announced_day > as_of_r) begin
          stat_nxt = ST_NOT_YET;
        end else if (outside) begin
          stat_nxt = ST_OUTSIDE;
        end else if (need_sum > (CNT_W + 1)'(MAX_PERIODS)) begin
          stat_nxt = ST_FULL;
        end else begin
          stat_nxt = ST_APPLIED;
        end
      end
      S_INS_S: begin
        if (add_s_r) begin
          fsm_op    = OP_INSERT;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      S_INS_E: begin
        if (add_e_r) begin
          fsm_op    = OP_INSERT;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      S_REPORT: begin
        if (slot_free) begin
          out_valid_nxt       = 1'b1;
          out_nxt.status      = stat_r;
          out_nxt.period_start = '0;
          out_nxt.period_end  = '0;
          out_nxt.last        = 1'b1;
        end
      end
      S_READ: begin
        if (slot_free) begin
          fsm_op               = OP_ROTATE;
          k_nxt                = k_r + CNT_W'(1);
          out_valid_nxt        = 1'b1;
          out_nxt.status       = ST_READ;
          out_nxt.period_start = cell_day[0];
          out_nxt.period_end   = read_end;
          out_nxt.last         = last_read;
        end
      end
      default: ;
    endcase
    // An epoch write brings the table back to the single epoch start.
    if (cfg_clear) begin
      count_nxt = CNT_W'(1);
    end
  end

  // Control bundle for the chain; an epoch write overrides the sequencer.
  always_comb begin
    ctl.op       = fsm_op;
    ctl.ins_day  = (state_r == S_INS_S) ? item_r.holiday_start : key_e;
    ctl.head_day = cell_day[0];
    ctl.key_s    = item_r.holiday_start;
    ctl.key_e    = key_e;
    if (cfg_clear) begin
      ctl.op      = OP_CLEAR;
      ctl.ins_day = (cfg_index == CFG_EPOCH_START) ? cfg_data : epoch_start_r;
    end
  end

  // Controller state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= CNT_W'(1);
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= in_data;
    end
    if (state_r == S_CHECK) begin
      ms_r <= match_s;
      me_r <= match_e;
    end
    stat_r  <= stat_nxt;
    add_s_r <= add_s_nxt;
    add_e_r <= add_e_nxt;
    out_r   <= out_nxt;
  end

  // Chain of boundary cells, head first.
  for (genvar i = 0; i < MAX_PERIODS; i++) begin : g_cell
    hpp_day_t l_day, r_day;
    logic     l_valid, r_valid;

    if (i == 0) begin : g_head
      assign l_day   = '0;
      assign l_valid = 1'b0;
    end else begin : g_body
      assign l_day   = cell_day[i-1];
      assign l_valid = cell_valid[i-1];
    end

    if (i == MAX_PERIODS - 1) begin : g_tail
      assign r_day   = '0;
      assign r_valid = 1'b0;
    end else begin : g_inner
      assign r_day   = cell_day[i+1];
      assign r_valid = cell_valid[i+1];
    end

    hpp_cell #(
      .IS_HEAD (i == 0)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .left_day    (l_day),
      .left_valid  (l_valid),
      .right_day   (r_day),
      .right_valid (r_valid),
      .day_o       (cell_day[i]),
      .valid_o     (cell_valid[i]),
      .match_s_o   (match_s[i]),
      .match_e_o   (match_e[i])
    );
  end

endmodule

[bench/hpp_score_pkg.sv]
// Scoreboard for the holiday period partition bench: a predictor of the boundary table
// and a queue of the result words it still owes.
// Depends on hpp_pkg for the word types, status codes and register indexes.
`timescale 1ns / 1ps

package hpp_score_pkg;
  import hpp_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam hpp_day_t DAY_MAX = '1;

  class partition_scoreboard;
    hpp_day_t    epoch_start;
    hpp_day_t    epoch_end;
    hpp_day_t    as_of_day;
    hpp_day_t    bounds[TABLE_DEPTH];
    int unsigned bound_count;
    hpp_out_t    due_words[$];
    int unsigned fails;

    function new();
      epoch_start = '0;
      epoch_end   = DAY_MAX;
      as_of_day   = DAY_MAX;
      fails       = 0;
      clear_bounds();
    endfunction

    // The table falls back to the single boundary at the epoch start.
    function void clear_bounds();
      foreach (bounds[i]) bounds[i] = '0;
      bounds[0]   = epoch_start;
      bound_count = 1;
    endfunction

    function bit has_bound(hpp_day_t d);
      for (int unsigned i = 0; i < bound_count; i++) begin
        if (bounds[i] == d) return 1'b1;
      end
      return 1'b0;
    endfunction

    // Sorted insert; a duplicate or a full table leaves the table as it is.
    function void insert_bound(hpp_day_t d);
      int unsigned pos;
      pos = 0;
      while (pos < bound_count && bounds[pos] < d) pos++;
      if (pos < bound_count && bounds[pos] == d) return;
      if (bound_count >= TABLE_DEPTH) return;
      for (int unsigned i = bound_count; i > pos; i--) bounds[i] = bounds[i-1];
      bounds[pos] = d;
      bound_count++;
    endfunction

    // Either epoch register clears the table; the as-of day does not.
    function void write_reg(hpp_cfg_idx_t idx, hpp_day_t value);
      case (idx)
        CFG_EPOCH_START: begin
          epoch_start = value;
          clear_bounds();
        end
        CFG_EPOCH_END: begin
          epoch_end = value;
          clear_bounds();
        end
        CFG_AS_OF_DAY: as_of_day = value;
        default: ;
      endcase
    endfunction

    // Works out the result words of one accepted input word.
    function void note_word(hpp_in_t w);
      hpp_out_t    r;
      bit          add_s;
      bit          add_e;
      int unsigned need;
      r      = '0;
      r.last = 1'b1;
      if (w.action == ACT_READ) begin
        for (int unsigned k = 0; k < bound_count; k++) begin
          r.status       = ST_READ;
          r.period_start = bounds[k];
          r.period_end   = (k + 1 < bound_count) ? bounds[k+1] - 1'b1 : epoch_end;
          r.last         = (k + 1 == bound_count);
          due_words.push_back(r);
        end
        return;
      end
      // Announcement first, then the epoch range, then room in the table.
      if (w.announced_day > as_of_day) begin
        r.status = ST_NOT_YET;
      end else if (w.holiday_start < epoch_start || w.holiday_end > epoch_end ||
                   w.holiday_start > w.holiday_end) begin
        r.status = ST_OUTSIDE;
      end else begin
        add_s = (w.holiday_start != epoch_start) && !has_bound(w.holiday_start);
        add_e = (w.holiday_end < epoch_end) && !has_bound(w.holiday_end + 1'b1);
        need  = add_s + add_e;
        if (bound_count + need > TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          if (add_s) insert_bound(w.holiday_start);
          if (add_e) insert_bound(w.holiday_end + 1'b1);
          r.status = ST_APPLIED;
        end
      end
      due_words.push_back(r);
    endfunction

    // Compares one accepted result word with the oldest one owed.
    function void check_word(hpp_out_t got);
      hpp_out_t want;
      if (due_words.size() == 0) begin
        fails++;
        $display("%0t: result word with none expected: status %0d start %0d end %0d last %0d",
                 $time, got.status, got.period_start, got.period_end, got.last);
        return;
      end
      want = due_words.pop_front();
      if (got.status !== want.status) begin
        fails++;
        $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
      end
      if (got.period_start !== want.period_start) begin
        fails++;
        $display("%0t: period_start expected %0d, got %0d", $time, want.period_start,
                 got.period_start);
      end
      if (got.period_end !== want.period_end) begin
        fails++;
        $display("%0t: period_end expected %0d, got %0d", $time, want.period_end,
                 got.period_end);
      end
      if (got.last !== want.last) begin
        fails++;
        $display("%0t: last expected %0d, got %0d", $time, want.last, got.last);
      end
    endfunction

    function int unsigned pending();
      return due_words.size();
    endfunction
  endclass

endpackage

[bench/tb_holiday_period_partition.sv]
// Top of the holiday period partition bench: drives directed and random words with
// random gaps and stalls, writes the registers between phases and checks every result.
// Depends on hpp_pkg, hpp_score_pkg and the holiday_period_partition block.
`timescale 1ns / 1ps

module tb_holiday_period_partition;
  import hpp_pkg::*;
  import hpp_score_pkg::*;

  localparam int unsigned ITEM_TARGET   = 310;
  localparam int unsigned MAX_WAIT      = 18;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned LONG_HOLD     = 400;

  logic                    clk       = 1'b0;
  logic                    rst_n     = 1'b0;
  logic                    in_valid  = 1'b0;
  hpp_in_t                 in_data   = '0;
  logic                    out_stall = 1'b0;
  logic                    cfg_valid = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  hpp_day_t                cfg_data  = '0;
  logic                    in_stall;
  logic                    out_valid;
  hpp_out_t                out_data;
  logic                    cfg_ready;

  partition_scoreboard sb;
  bit                  quiet      = 1'b0;
  int unsigned         sink_hold  = 0;
  int unsigned         words_sent = 0;

  holiday_period_partition #(
    .MAX_PERIODS(TABLE_DEPTH)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  // Every accepted result word is checked against the oldest one owed.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_word(out_data);
  end

  // Result side: a random stall before each word, or one long hold when asked for.
  initial begin : result_sink
    int unsigned n;
    @(posedge clk);
    forever begin
      if (sink_hold > 0) begin
        n         = sink_hold;
        sink_hold = 0;
      end else begin
        n = quiet ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic hpp_day_t rand_day();
    return hpp_day_t'($urandom);
  endfunction

  // Days bunch at the edges of [lo, hi] so that boundaries collide often.
  function automatic hpp_day_t pick_day(hpp_day_t lo, hpp_day_t hi);
    int unsigned span;
    int unsigned near;
    if (lo >= hi) return lo;
    span = hi - lo;
    near = (span < 40) ? span : 40;
    case ($urandom_range(0, 9))
      0:          return lo;
      1:          return hi;
      2, 3, 4, 5: return lo + hpp_day_t'($urandom_range(0, near));
      6, 7:       return hi - hpp_day_t'($urandom_range(0, near));
      default:    return hpp_day_t'($urandom_range(hi, lo));
    endcase
  endfunction

  function automatic hpp_in_t add_word(hpp_day_t ann, hpp_day_t hs, hpp_day_t he);
    hpp_in_t w;
    w.action        = ACT_ADD;
    w.announced_day = ann;
    w.holiday_start = hs;
    w.holiday_end   = he;
    return w;
  endfunction

  // The day fields of a read word carry noise.
  function automatic hpp_in_t read_word();
    return add_word(rand_day(), rand_day(), rand_day()) | {ACT_READ, {3*DAY_BITS{1'b0}}};
  endfunction

  // Mostly well-formed adds inside the epoch, with reads, noise and broken words mixed in.
  function automatic hpp_in_t random_word();
    hpp_in_t     w;
    hpp_day_t    a;
    hpp_day_t    b;
    hpp_day_t    ann;
    int unsigned r;
    a   = pick_day(sb.epoch_start, sb.epoch_end);
    b   = pick_day(sb.epoch_start, sb.epoch_end);
    ann = ($urandom_range(0, 3) == 0) ? sb.as_of_day
                                      : hpp_day_t'($urandom_range(0, sb.as_of_day));
    w   = add_word(ann, (a < b) ? a : b, (a < b) ? b : a);
    r   = $urandom_range(0, 99);
    if (r < 15) begin
      w.action = ACT_READ;
    end else if (r < 25) begin
      w = add_word(rand_day(), rand_day(), rand_day());
      w.action = hpp_action_t'($urandom_range(0, 1));
    end else if (r < 32) begin
      // Announced too late.
      if (sb.as_of_day != DAY_MAX)
        w.announced_day = hpp_day_t'($urandom_range(sb.as_of_day + 1, DAY_MAX));
    end else if (r < 40) begin
      // Starting before the epoch, ending after it, or reversed.
      case ($urandom_range(0, 2))
        0: if (sb.epoch_start != 0)
          w.holiday_start = hpp_day_t'($urandom_range(0, sb.epoch_start - 1));
        1: if (sb.epoch_end != DAY_MAX)
          w.holiday_end = hpp_day_t'($urandom_range(sb.epoch_end + 1, DAY_MAX));
        default: begin
          w.holiday_start = (a < b) ? b : a;
          w.holiday_end   = (a < b) ? a : b;
        end
      endcase
    end
    return w;
  endfunction

  // Offers one input word after a random gap and holds it until it is taken.
  task automatic send_word(input hpp_in_t w);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    sb.note_word(w);
    words_sent++;
  endtask

  task automatic write_reg(input hpp_cfg_idx_t idx, input hpp_day_t value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.write_reg(idx, value);
    @(posedge clk);
  endtask

  // Stops offering words until every owed result has come and the block has settled.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Full epoch and many short holidays near its start, so that the table fills up.
  task automatic fill_phase();
    hpp_day_t d;
    write_reg(CFG_EPOCH_START, '0);
    write_reg(CFG_EPOCH_END, DAY_MAX);
    write_reg(CFG_AS_OF_DAY, DAY_MAX);
    repeat (45) begin
      d = hpp_day_t'($urandom_range(1, 300));
      send_word(add_word(rand_day(), d, d + hpp_day_t'($urandom_range(0, 2))));
    end
    send_word(read_word());
  endtask

  initial begin : stimulus
    int unsigned phase;
    int unsigned n;
    bit          keep;
    hpp_day_t    es;
    hpp_day_t    ee;
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words on the reset settings: epoch edges, duplicates, a reversed span.
    send_word(read_word());
    send_word(add_word('0, '0, DAY_MAX));
    send_word(add_word(DAY_MAX, 20'd100, 20'd199));
    send_word(add_word(20'd5, 20'd100, 20'd199));
    send_word(add_word('0, 20'd300, 20'd250));
    send_word(add_word('0, 20'd150, 20'd150));
    send_word(read_word());
    drain();

    // Nothing announced after day zero counts, even ahead of a range fault.
    write_reg(CFG_AS_OF_DAY, '0);
    send_word(add_word(20'd1, 20'd10, 20'd20));
    send_word(add_word(DAY_MAX, 20'd300, 20'd250));
    send_word(add_word('0, DAY_MAX, DAY_MAX));
    send_word(read_word());
    drain();

    // A write to the unused index must leave the table alone.
    write_reg(CFG_UNUSED, 20'd12345);
    send_word(read_word());
    drain();

    // Narrow epoch: holidays sticking out on either side, and ones touching its edges.
    write_reg(CFG_EPOCH_START, 20'd500);
    write_reg(CFG_EPOCH_END, 20'd600);
    write_reg(CFG_AS_OF_DAY, DAY_MAX);
    send_word(add_word('0, 20'd499, 20'd550));
    send_word(add_word('0, 20'd550, 20'd601));
    send_word(add_word('0, 20'd500, 20'd600));
    send_word(add_word('0, 20'd500, 20'd550));
    send_word(add_word('0, 20'd551, 20'd600));
    send_word(read_word());
    drain();

    // Single-day epoch on the last day number.
    write_reg(CFG_EPOCH_START, DAY_MAX);
    write_reg(CFG_EPOCH_END, DAY_MAX);
    send_word(add_word('0, DAY_MAX, DAY_MAX));
    send_word(read_word());

    // Random phases, each on its own settings and idling mode.
    phase = 0;
    while (words_sent < ITEM_TARGET) begin
      drain();
      quiet = ($urandom_range(0, 3) == 0);
      case (phase)
        2, 7: fill_phase();
        4: begin
          // Fill the table, then hold the result side off while words keep coming.
          fill_phase();
          drain();
          sink_hold = LONG_HOLD;
          send_word(read_word());
          repeat (6) send_word(random_word());
          send_word(read_word());
        end
        default: begin
          keep = 1'b0;
          case ($urandom_range(0, 6))
            0: begin
              es = '0;
              ee = DAY_MAX;
            end
            1: begin
              es = rand_day();
              ee = (es > DAY_MAX - 3000) ? DAY_MAX : es + hpp_day_t'($urandom_range(0, 3000));
            end
            2: begin
              es = DAY_MAX - hpp_day_t'($urandom_range(0, 500));
              ee = DAY_MAX;
            end
            3: begin
              es = '0;
              ee = hpp_day_t'($urandom_range(0, 2000));
            end
            4: begin
              es = rand_day();
              ee = es;
            end
            5: begin
              es = rand_day();
              ee = rand_day();
            end
            default: keep = 1'b1;
          endcase
          if (!keep) begin
            if ($urandom_range(0, 1) == 0) begin
              write_reg(CFG_EPOCH_START, es);
              write_reg(CFG_EPOCH_END, ee);
            end else begin
              write_reg(CFG_EPOCH_END, ee);
              write_reg(CFG_EPOCH_START, es);
            end
          end
          case ($urandom_range(0, 4))
            0: write_reg(CFG_AS_OF_DAY, DAY_MAX);
            1: write_reg(CFG_AS_OF_DAY, '0);
            2: write_reg(CFG_AS_OF_DAY, rand_day());
            3: write_reg(CFG_AS_OF_DAY, sb.epoch_end);
            default: ;
          endcase
          if ($urandom_range(0, 7) == 0) write_reg(CFG_UNUSED, rand_day());
          n = $urandom_range(8, 30);
          repeat (n) begin
            send_word(random_word());
            if ($urandom_range(0, 39) == 0) drain();
          end
        end
      endcase
      phase++;
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/hpp_pkg.sv
hw/rtl/hpp_cell.sv
hw/rtl/holiday_period_partition.sv
bench/hpp_score_pkg.sv
bench/tb_holiday_period_partition.sv
